// ===== rtl/sax_enc_pkg.sv =====
// sax_enc_pkg: shared constants, payload structs and control structs
// of the SAX symbol encoder; used by every file in rtl/
// no dependencies
package sax_enc_pkg;

	// table and arithmetic sizes
	localparam int TABLE_DEPTH        = 256;
	localparam int ADDR_W             = $clog2(TABLE_DEPTH);
	localparam int SLOT_W             = 9;
	localparam int SAMPLE_WIDTH       = 16;
	localparam int MAX_SEGMENT_LENGTH = 1024;
	localparam int LEN_W              = 11;
	localparam int CNT_W              = (MAX_SEGMENT_LENGTH > 1) ? $clog2(MAX_SEGMENT_LENGTH) : 1;
	localparam int MAX_SEGMENTS       = 256;
	localparam int SEGS_W             = 9;
	localparam int SEG_IDX_W          = 8;
	localparam int SYMBOL_W           = 8;
	localparam int SUM_W              = SAMPLE_WIDTH + CNT_W;
	localparam int PROD_W             = SAMPLE_WIDTH + LEN_W + 1;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_SEG_LEN   = 1'b0;
	localparam logic REG_SEG_COUNT = 1'b1;
	localparam logic [LEN_W-1:0]  SEG_LEN_RESET   = LEN_W'(16);
	localparam logic [SEGS_W-1:0] SEG_COUNT_RESET = SEGS_W'(16);

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// input transaction
	typedef struct packed {
		logic                           operation;
		logic [SLOT_W-1:0]              table_slot;
		logic signed [SAMPLE_WIDTH-1:0] value;
	} in_item_t;

	// output transaction
	typedef struct packed {
		logic [SYMBOL_W-1:0]  symbol;
		logic [SEG_IDX_W-1:0] segment_index;
		logic                 last_segment;
	} out_item_t;

	// table write port
	typedef struct packed {
		logic                           en;
		logic [ADDR_W-1:0]              addr;
		logic signed [SAMPLE_WIDTH-1:0] data;
	} tbl_wr_t;

	// search unit status
	typedef struct packed {
		logic busy;
		logic done;
	} srch_status_t;

endpackage

// ===== rtl/sax_symbol_encoder.sv =====
// sax_symbol_encoder: top level of the SAX symbol encoder
// depends on sax_enc_pkg, sax_enc_table and sax_enc_search
//
// Usage:
//   Input channel req (req_valid/req_stall): operation 0 writes breakpoint
//   slot table_slot (1..256) with value; operation 1 adds value (Q4.12) to
//   the running segment sum. Writes and non-final samples do not stall.
//   The sample that completes a segment starts an 8-step binary search over
//   the breakpoint table; each step is a table read, a multiply by the
//   segment length and a compare in the shared search unit, and the result
//   then moves to the output register; the next input transaction is taken
//   once the search unit has handed its result over and returned to idle.
//   req_stall is high while the search runs or its result waits for the
//   output register.
//   Output channel res (res_valid/res_stall): one transaction per segment
//   with symbol, segment_index and last_segment. The output register holds
//   while res_stall is high; the search unit then holds its result and the
//   input stays stalled.
//   Configuration over APB: samples_per_segment at 0x0, segment_count at 0x4;
//   the user writes them only while the block is idle, not enforced by the
//   block. pready is always high. Reset clears the sum, counters and both
//   channels; registers return to 16. Breakpoint slots hold no value until written.
module sax_symbol_encoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sax_enc_pkg::PADDR_W-1:0]    paddr,
	input  logic [sax_enc_pkg::PDATA_W-1:0]    pwdata,
	output logic [sax_enc_pkg::PDATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  sax_enc_pkg::in_item_t              req,
	output logic                               res_valid,
	input  logic                               res_stall,
	output sax_enc_pkg::out_item_t             res
);
	import sax_enc_pkg::*;

	logic [LEN_W-1:0]               seg_len_q;
	logic [SEGS_W-1:0]              seg_count_q;
	logic [LEN_W-1:0]               seg_len;
	logic [SEGS_W-1:0]              seg_total;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [SUM_W-1:0]        sum_next;
	logic [CNT_W-1:0]               cnt_q;
	logic [SEG_IDX_W-1:0]           seg_q;
	logic [SEG_IDX_W-1:0]           idx_q;
	logic                           last_q;
	logic                           req_acc;
	logic                           seg_end;
	logic                           is_last;
	logic                           start;
	logic                           take;
	logic                           res_valid_q;
	out_item_t                      res_q;
	tbl_wr_t                        tbl_wr;
	logic [ADDR_W-1:0]              rd_addr;
	logic signed [SAMPLE_WIDTH-1:0] rd_data;
	srch_status_t                   srch_st;
	logic [SYMBOL_W-1:0]            srch_symbol;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_len_q   <= SEG_LEN_RESET;
			seg_count_q <= SEG_COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SEG_LEN:   seg_len_q   <= pwdata[LEN_W-1:0];
				REG_SEG_COUNT: seg_count_q <= pwdata[SEGS_W-1:0];
				default:       seg_len_q   <= seg_len_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SEG_LEN:   prdata = PDATA_W'(seg_len_q);
			REG_SEG_COUNT: prdata = PDATA_W'(seg_count_q);
			default:       prdata = '0;
		endcase
	end

	// effective segment length and series length
	always_comb begin
		priority if (seg_len_q == '0) begin
			seg_len = LEN_W'(1);
		end else if (seg_len_q > LEN_W'(MAX_SEGMENT_LENGTH)) begin
			seg_len = LEN_W'(MAX_SEGMENT_LENGTH);
		end else begin
			seg_len = seg_len_q;
		end
		priority if (seg_count_q == '0) begin
			seg_total = SEGS_W'(1);
		end else if (seg_count_q > SEGS_W'(MAX_SEGMENTS)) begin
			seg_total = SEGS_W'(MAX_SEGMENTS);
		end else begin
			seg_total = seg_count_q;
		end
	end

	// input transaction decode
	assign req_stall = srch_st.busy;
	assign req_acc   = req_valid && !req_stall;
	assign sum_next  = sum_q + SUM_W'(req.value);
	assign seg_end   = !((LEN_W'(cnt_q) + LEN_W'(1)) < seg_len);
	assign is_last   = (SEGS_W'(seg_q) + SEGS_W'(1)) >= seg_total;
	assign start     = req_acc && (req.operation == OP_SAMPLE) && seg_end;

	always_comb begin
		tbl_wr.en   = req_acc && (req.operation == OP_WRITE) && (req.table_slot != '0)
			&& (req.table_slot <= SLOT_W'(TABLE_DEPTH));
		tbl_wr.addr = ADDR_W'(req.table_slot - SLOT_W'(1));
		tbl_wr.data = req.value;
	end

	// running sum and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			seg_q <= '0;
		end else if (req_acc && req.operation == OP_SAMPLE) begin
			if (seg_end) begin
				sum_q <= '0;
				cnt_q <= '0;
				seg_q <= is_last ? '0 : seg_q + SEG_IDX_W'(1);
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// segment tag held during the search
	always_ff @(posedge clk) begin
		if (start) begin
			idx_q  <= seg_q;
			last_q <= is_last;
		end
	end

	sax_enc_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sax_enc_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.sum     (sum_next),
		.seg_len (seg_len),
		.take    (take),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.status  (srch_st),
		.symbol  (srch_symbol)
	);

	// output register
	assign take = srch_st.done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.symbol        <= srch_symbol;
			res_q.segment_index <= idx_q;
			res_q.last_segment  <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/sax_enc_table.sv =====
// sax_enc_table: breakpoint memory, one write port and one registered read port
// depends on sax_enc_pkg
module sax_enc_table (
	input  logic                                        clk,
	input  sax_enc_pkg::tbl_wr_t                        wr,
	input  logic [sax_enc_pkg::ADDR_W-1:0]              rd_addr,
	output logic signed [sax_enc_pkg::SAMPLE_WIDTH-1:0] rd_data
);
	import sax_enc_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] mem [TABLE_DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/sax_enc_search.sv =====
// sax_enc_search: binary search over the breakpoint table with one shared
// multiplier and comparator; each step passes through the address, multiply and compare states
// depends on sax_enc_pkg; reads the table through sax_enc_table
module sax_enc_search (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic signed [sax_enc_pkg::SUM_W-1:0]        sum,
	input  logic [sax_enc_pkg::LEN_W-1:0]               seg_len,
	input  logic                                        take,
	output logic [sax_enc_pkg::ADDR_W-1:0]              rd_addr,
	input  logic signed [sax_enc_pkg::SAMPLE_WIDTH-1:0] rd_data,
	output sax_enc_pkg::srch_status_t                   status,
	output logic [sax_enc_pkg::SYMBOL_W-1:0]            symbol
);
	import sax_enc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADDR = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]               state_q;
	logic [ADDR_W-1:0]        lo_q;
	logic [ADDR_W-1:0]        hi_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [LEN_W-1:0]         len_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ADDR_W:0]          mid_w;
	logic [ADDR_W-1:0]        mid;
	logic                     below;
	logic [ADDR_W-1:0]        lo_n;
	logic [ADDR_W-1:0]        hi_n;

	// upper midpoint of the open range
	always_comb begin
		mid_w = ({1'b0, lo_q} + {1'b0, hi_q} + (ADDR_W + 1)'(1)) >> 1;
		mid   = mid_w[ADDR_W-1:0];
	end

	// slot mid lives at index mid-1
	assign rd_addr = mid - ADDR_W'(1);

	// range update from the scaled breakpoint compare
	always_comb begin
		below = prod_q < PROD_W'(sum_q);
		lo_n  = lo_q;
		hi_n  = hi_q;
		if (below) begin
			lo_n = mid;
		end else begin
			hi_n = mid - ADDR_W'(1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ADDR;
						lo_q    <= '0;
						hi_q    <= ADDR_W'(TABLE_DEPTH - 1);
					end
				end
				S_ADDR: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					lo_q    <= lo_n;
					hi_q    <= hi_n;
					state_q <= (lo_n == hi_n) ? S_DONE : S_ADDR;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand capture and shared multiplier
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			sum_q <= sum;
			len_q <= seg_len;
		end
		if (state_q == S_MUL) begin
			prod_q <= $signed(rd_data) * $signed({1'b0, len_q});
		end
	end

	assign status.busy = (state_q != S_IDLE);
	assign status.done = (state_q == S_DONE);
	assign symbol      = SYMBOL_W'(lo_q);

	// checks
	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> lo_q <= hi_q)
		else $error("search range inverted");
	a_done_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> lo_q == hi_q)
		else $error("search finished with open range");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("search started while busy");
	a_mul_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_CMP)
		else $error("compare step skipped");

endmodule
